FILE: rtl/lwc_pkg.sv
`timescale 1ns / 1ps
// lwc_pkg: shared types and constants of the listen window controller
// no dependencies; used by every rtl file of the block except lwc_out_if

package lwc_pkg;

  // configuration register width and register file index width
  localparam int CFG_BITS  = 24;
  localparam int CFG_IDX_W = 3;

  // default timer width
  localparam int TIME_BITS_DEF = 24;

  // input payload field widths
  localparam int DT_BITS = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_CAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PONDER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_SILENCE = 3'd4;

  // reset values of the registers
  localparam logic [CFG_BITS-1:0] RST_BUSY_CAP    = 24'd30000;
  localparam logic [CFG_BITS-1:0] RST_WINDOW_MAX  = 24'd10000;
  localparam logic [CFG_BITS-1:0] RST_PONDER      = 24'd3000;
  localparam logic [CFG_BITS-1:0] RST_MIN_SPEECH  = 24'd500;
  localparam logic [CFG_BITS-1:0] RST_END_SILENCE = 24'd1000;

  // current limit settings handed from the register file to the core
  typedef struct packed {
    logic [CFG_BITS-1:0] busy_cap_ms;
    logic [CFG_BITS-1:0] window_max_ms;
    logic [CFG_BITS-1:0] ponder_limit;
    logic [CFG_BITS-1:0] speech_min;
    logic [CFG_BITS-1:0] end_silence_ms;
  } cfg_t;

  // one tick request
  typedef struct packed {
    logic               wake_seen;
    logic               speech_now;
    logic               voice_task_busy;
    logic [DT_BITS-1:0] elapsed_ms;
  } tick_t;

  // one tick result
  typedef struct packed {
    logic hold_event;
    logic listening_now;
  } res_t;

endpackage

FILE: rtl/lwc_in_if.sv
`timescale 1ns / 1ps
// lwc_in_if: tick request channel with valid/ready handshake
// depends on lwc_pkg for field widths

interface lwc_in_if import lwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               wake_seen;
  logic               speech_now;
  logic               voice_task_busy;
  logic [DT_BITS-1:0] elapsed_ms;

  modport source (output valid, wake_seen, speech_now, voice_task_busy, elapsed_ms,
                  input ready);
  modport sink (input valid, wake_seen, speech_now, voice_task_busy, elapsed_ms,
                output ready);
endinterface

FILE: rtl/lwc_out_if.sv
`timescale 1ns / 1ps
// lwc_out_if: tick result channel with valid/ready handshake
// no package dependency

interface lwc_out_if;
  logic valid;
  logic ready;
  logic hold_event;
  logic listening_now;

  modport source (output valid, hold_event, listening_now, input ready);
  modport sink (input valid, hold_event, listening_now, output ready);
endinterface

FILE: rtl/lwc_cfg_regs.sv
`timescale 1ns / 1ps
// lwc_cfg_regs: the five limit registers with their write decoder
// depends on lwc_pkg

module lwc_cfg_regs import lwc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t regs;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.busy_cap_ms    <= RST_BUSY_CAP;
      regs.window_max_ms  <= RST_WINDOW_MAX;
      regs.ponder_limit   <= RST_PONDER;
      regs.speech_min     <= RST_MIN_SPEECH;
      regs.end_silence_ms <= RST_END_SILENCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUSY_CAP:    regs.busy_cap_ms    <= cfg_wdata;
        REG_WINDOW_MAX:  regs.window_max_ms  <= cfg_wdata;
        REG_PONDER:      regs.ponder_limit   <= cfg_wdata;
        REG_MIN_SPEECH:  regs.speech_min     <= cfg_wdata;
        REG_END_SILENCE: regs.end_silence_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: rtl/lwc_core.sv
`timescale 1ns / 1ps
// lwc_core: listen mode flag, the three saturating timers and the close decision
// depends on lwc_pkg; settings come from lwc_cfg_regs

module lwc_core import lwc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  tick_t tick,
  input  cfg_t  cfg,
  output res_t  res
);

  // compare width covers both timers and limits
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic                 mode_listening;
  logic [TIME_BITS-1:0] window_time;
  logic [TIME_BITS-1:0] speech_time;
  logic [TIME_BITS-1:0] silence_time;

  logic                 mode_listening_next;
  logic [TIME_BITS-1:0] window_time_next;
  logic [TIME_BITS-1:0] speech_time_next;
  logic [TIME_BITS-1:0] silence_time_next;

  logic                 active;
  logic                 close;
  logic [TIME_BITS-1:0] win_base;
  logic [TIME_BITS-1:0] sp_base;
  logic [TIME_BITS-1:0] si_base;
  logic [TIME_BITS-1:0] win_new;
  logic [TIME_BITS-1:0] sp_add;
  logic [TIME_BITS-1:0] si_add;
  logic [TIME_BITS-1:0] sp_upd;
  logic [TIME_BITS-1:0] si_upd;
  logic [CMP_BITS-1:0]  win_c;
  logic [CMP_BITS-1:0]  sp_c;
  logic [CMP_BITS-1:0]  si_c;

  // add elapsed time, clamp at all ones
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [DT_BITS-1:0]   b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // a wake while idle starts from cleared timers
  assign active   = mode_listening | tick.wake_seen;
  assign win_base = mode_listening ? window_time  : '0;
  assign sp_base  = mode_listening ? speech_time  : '0;
  assign si_base  = mode_listening ? silence_time : '0;

  assign win_new = sat_add(win_base, tick.elapsed_ms);
  assign sp_add  = sat_add(sp_base, tick.elapsed_ms);
  assign si_add  = sat_add(si_base, tick.elapsed_ms);
  assign sp_upd  = tick.speech_now ? sp_add : sp_base;
  assign si_upd  = tick.speech_now ? '0 : si_add;

  assign win_c = CMP_BITS'(win_new);
  assign sp_c  = CMP_BITS'(sp_upd);
  assign si_c  = CMP_BITS'(si_upd);

  // close decision and next state
  always_comb begin
    close             = 1'b0;
    speech_time_next  = sp_base;
    silence_time_next = si_base;
    if (tick.voice_task_busy) begin
      close = win_c >= CMP_BITS'(cfg.busy_cap_ms);
    end else if (win_c >= CMP_BITS'(cfg.window_max_ms)) begin
      close = 1'b1;
    end else begin
      speech_time_next  = sp_upd;
      silence_time_next = si_upd;
      close = ((sp_upd == '0) && (win_c >= CMP_BITS'(cfg.ponder_limit))) ||
              ((sp_c >= CMP_BITS'(cfg.speech_min)) &&
               (si_c >= CMP_BITS'(cfg.end_silence_ms)));
    end
    mode_listening_next = ~close;
    window_time_next    = win_new;
  end

  // result of this tick
  assign res.hold_event    = active & ~close;
  assign res.listening_now = active & ~close;

  // state registers, idle ticks without a wake leave them alone
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_listening <= 1'b0;
      window_time    <= '0;
      speech_time    <= '0;
      silence_time   <= '0;
    end else if (take && active) begin
      mode_listening <= mode_listening_next;
      window_time    <= window_time_next;
      speech_time    <= speech_time_next;
      silence_time   <= silence_time_next;
    end
  end

endmodule

FILE: rtl/listen_window_controller_unit.sv
`timescale 1ns / 1ps
// listen_window_controller_unit: top level of the listen window controller
// depends on lwc_pkg, lwc_in_if, lwc_out_if, lwc_cfg_regs and lwc_core

// Every tick request gives exactly one result, in the cycle after it is
// accepted, and a new request is taken in every cycle while the result
// register is empty or being drained. The whole tick (window timer add,
// speech and silence timer adds, limit compares) is settled by one level of
// logic between the state registers and the result register. Timers are
// TIME_BITS wide and saturate; limit registers are written through cfg_we,
// cfg_index and cfg_wdata, and a write to an unknown index is ignored.

module listen_window_controller_unit import lwc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata,
  lwc_in_if.sink               in_ch,
  lwc_out_if.source            out_ch
);

  cfg_t  cfg;
  tick_t tick;
  res_t  res;
  res_t  res_q;
  logic  res_valid;
  logic  take;

  lwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // request payload
  assign tick.wake_seen       = in_ch.wake_seen;
  assign tick.speech_now      = in_ch.speech_now;
  assign tick.voice_task_busy = in_ch.voice_task_busy;
  assign tick.elapsed_ms      = in_ch.elapsed_ms;

  // take a request when the result slot is free or leaving this cycle
  assign in_ch.ready = ~res_valid | out_ch.ready;
  assign take        = in_ch.valid & in_ch.ready;

  lwc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .tick (tick),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.hold_event    = res_q.hold_event;
  assign out_ch.listening_now = res_q.listening_now;

endmodule

FILE: tb/listen_window_controller_unit_tb.sv
`timescale 1ns / 1ps
// listen_window_controller_unit_tb: self-checking bench of the listen window controller
// depends on lwc_pkg, lwc_in_if, lwc_out_if and listen_window_controller_unit

module listen_window_controller_unit_tb;
  import lwc_pkg::*;

  localparam int TIME_BITS   = TIME_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 3;

  // first register index past the defined ones; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_BITS-1:0]  cfg_wdata;

  lwc_in_if  in_ch ();
  lwc_out_if out_ch ();

  listen_window_controller_unit #(.TIME_BITS(TIME_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // shadow of the window state and limit registers
  cfg_t                 limits;
  logic                 win_open = 1'b0;
  logic [TIME_BITS-1:0] window_ms = '0;
  logic [TIME_BITS-1:0] talk_time = '0;
  logic [TIME_BITS-1:0] quiet_time = '0;

  res_t pending_results[$];
  int   window_ticks = 0;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   stall_left = 0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
                                                   logic [DT_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // advance the shadow window by one tick and return the expected result
  function automatic res_t advance_window(tick_t t);
    res_t r;
    logic shut;
    shut = 1'b0;
    r = '0;
    if (!win_open) begin
      if (!t.wake_seen) return r;
      win_open = 1'b1;
      window_ms = '0;
      talk_time = '0;
      quiet_time = '0;
    end
    window_ms = sat_add(window_ms, t.elapsed_ms);
    if (t.voice_task_busy) begin
      // only the hard cap counts while busy
      shut = (window_ms >= limits.busy_cap_ms);
    end else if (window_ms >= limits.window_max_ms) begin
      shut = 1'b1;
    end else begin
      if (t.speech_now) begin
        talk_time = sat_add(talk_time, t.elapsed_ms);
        quiet_time = '0;
      end else begin
        quiet_time = sat_add(quiet_time, t.elapsed_ms);
      end
      shut = (talk_time == '0 && window_ms >= limits.ponder_limit) ||
             (talk_time >= limits.speech_min && quiet_time >= limits.end_silence_ms);
    end
    if (shut) win_open = 1'b0;
    r.hold_event = !shut;
    r.listening_now = win_open;
    return r;
  endfunction

  function automatic tick_t make_tick(logic w, logic s, logic b, logic [DT_BITS-1:0] dt);
    tick_t t;
    t.wake_seen = w;
    t.speech_now = s;
    t.voice_task_busy = b;
    t.elapsed_ms = dt;
    return t;
  endfunction

  // mostly short steps, sometimes long or the full range
  function automatic logic [DT_BITS-1:0] pick_dt();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return DT_BITS'($urandom_range(0, 400));
      6, 7:             return DT_BITS'($urandom_range(0, 4000));
      8:                return DT_BITS'($urandom_range(0, 65535));
      default:          return '1;
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:             return '0;
      1:             return '1;
      2, 3, 4:       return CFG_BITS'($urandom_range(0, 500));
      5, 6, 7, 8:    return CFG_BITS'($urandom_range(0, 12000));
      default:       return CFG_BITS'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_limits();
    cfg_t l;
    l.busy_cap_ms = pick_limit();
    l.window_max_ms = pick_limit();
    l.ponder_limit = pick_limit();
    l.speech_min = pick_limit();
    l.end_silence_ms = pick_limit();
    return l;
  endfunction

  function automatic cfg_t default_limits();
    cfg_t l;
    l.busy_cap_ms = RST_BUSY_CAP;
    l.window_max_ms = RST_WINDOW_MAX;
    l.ponder_limit = RST_PONDER;
    l.speech_min = RST_MIN_SPEECH;
    l.end_silence_ms = RST_END_SILENCE;
    return l;
  endfunction

  // result checker and receiver side ready
  task automatic check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $error("result with no pending request: hold_event %0d listening_now %0d",
             got.hold_event, got.listening_now);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.hold_event !== want.hold_event) begin
        $error("hold_event: expected %0d, actual %0d", want.hold_event, got.hold_event);
        fail_count++;
      end
      if (got.listening_now !== want.listening_now) begin
        $error("listening_now: expected %0d, actual %0d", want.listening_now,
               got.listening_now);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.hold_event = out_ch.hold_event;
        got.listening_now = out_ch.listening_now;
        check_result(got);
      end
      // long hold-off counted here, otherwise random stalls
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // send one tick request, predict its result once accepted
  task automatic send_tick(tick_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.wake_seen <= t.wake_seen;
    in_ch.speech_now <= t.speech_now;
    in_ch.voice_task_busy <= t.voice_task_busy;
    in_ch.elapsed_ms <= t.elapsed_ms;
    do @(posedge clk); while (!in_ch.ready);
    if (win_open || t.wake_seen) window_ticks++;
    pending_results.push_back(advance_window(t));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic drive_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write all limits while nothing is in flight; spares hit unused indexes
  task automatic program_limits(cfg_t l, bit with_spares);
    wait_drained();
    drive_reg(REG_BUSY_CAP, l.busy_cap_ms);
    drive_reg(REG_WINDOW_MAX, l.window_max_ms);
    drive_reg(REG_PONDER, l.ponder_limit);
    drive_reg(REG_MIN_SPEECH, l.speech_min);
    drive_reg(REG_END_SILENCE, l.end_silence_ms);
    if (with_spares) begin
      for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
        drive_reg(CFG_IDX_W'(i), CFG_BITS'($urandom));
    end
    cfg_we <= 1'b0;
    limits = l;
  endtask

  // one wake followed by a run of ticks with bursts of talk
  task automatic run_window_session();
    int   len;
    logic talking;
    len = $urandom_range(1, 60);
    talking = 1'($urandom_range(0, 1));
    send_tick(make_tick(1'b1, 1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0),
                        pick_dt()));
    for (int i = 0; i < len && win_open; i++) begin
      if ($urandom_range(0, 3) == 0) talking = !talking;
      send_tick(make_tick(($urandom_range(0, 15) == 0),
                          talking ^ ($urandom_range(0, 9) == 0),
                          ($urandom_range(0, 9) == 0), pick_dt()));
    end
  endtask

  function automatic tick_t noise_tick();
    return make_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     DT_BITS'($urandom_range(0, 65535)));
  endfunction

  // each way to close a window, with reset limits
  task automatic test_default_windows();
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 16'hFFFF));  // idle, no wake
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 16'd0));     // wake, zero step
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 16'd600));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd999));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd1));     // ends on silence after speech
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd500));   // idle, timers kept
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 16'hFFFF));  // busy cap on the wake tick
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 16'd2999));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd1));     // ends on ponder time
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 16'd100));
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 16'd9000));  // busy, speech not counted
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 16'd899));   // wake while open changes nothing
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd1));     // ends on window limit
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 16'd200));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd900));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 16'd100));   // speech clears silence
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd999));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 16'd300));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 16'd29000)); // busy cap reached
  endtask

  // zero and full-scale limits, plus writes to unused indexes
  task automatic test_limit_extremes();
    cfg_t l;
    program_limits('0, 1'b1);
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 16'd0));
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 16'd0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd0));
    l = '1;
    l.speech_min = '0;
    l.end_silence_ms = '0;
    program_limits(l, 1'b1);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 16'd5));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 16'd0));
  endtask

  // all limits at full scale: the window closes only when its timer saturates
  task automatic test_timer_saturation();
    int k;
    program_limits('1, 1'b0);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 16'hFFFF));
    k = 0;
    while (win_open && k < 300) begin
      send_tick(make_tick(1'b0, k[0], (k % 3 == 0), 16'hFFFF));
      k++;
    end
  endtask

  // receiver holds off while requests keep coming, then a full pause
  task automatic test_backpressure();
    program_limits(default_limits(), 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 300;
    repeat (40)
      send_tick(make_tick(($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 7) == 0), pick_dt()));
    wait_drained();
    repeat (20)
      send_tick(make_tick(($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 7) == 0), pick_dt()));
  endtask

  // sessions with random content and noise, new limits after each hundred or more window ticks
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_ticks);
    int goal;
    int next_setting;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = window_ticks + n_ticks;
    next_setting = window_ticks;
    while (window_ticks < goal) begin
      if (window_ticks >= next_setting) begin
        program_limits(random_limits(), ($urandom_range(0, 3) == 0));
        next_setting = window_ticks + 100;
      end
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_tick(noise_tick());
      run_window_session();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.wake_seen = 1'b0;
    in_ch.speech_now = 1'b0;
    in_ch.voice_task_busy = 1'b0;
    in_ch.elapsed_ms = '0;
    limits = default_limits();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 78;
    test_default_windows();
    test_limit_extremes();
    test_timer_saturation();
    test_random_traffic(15, 78, 200);
    test_backpressure();
    test_random_traffic(78, 15, 200);
    test_random_traffic(0, 0, 200);

    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
